>>> rtl/core/collinear_pin_chain_builder_unit_defines.svh
// Assertion macros shared by the collinear pin chain builder RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef COLLINEAR_PIN_CHAIN_BUILDER_UNIT_DEFINES_SVH
`define COLLINEAR_PIN_CHAIN_BUILDER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CPCB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/cpcb_pkg.sv
// Package for the collinear pin chain builder: widths, payload structs,
// status codes, controller states and controller-to-datapath command types.
// No dependencies.
package cpcb_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_W    = 24;
  localparam int TOL_W      = 23;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int K_W        = CNT_W;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int EX_W       = COORD_W + K_W + 3;
  localparam int MAG_W      = EX_W;
  localparam int LO_W       = (MAG_W + 1) / 2;
  localparam int HI_W       = MAG_W - LO_W;
  localparam int TK_W       = TOL_W + K_W;
  localparam int TKH_W      = TK_W - LO_W;
  localparam int LIM_W      = 2 * TK_W;
  localparam int ACC_W      = 2 * MAG_W + 1;
  localparam int MA_W       = MAG_W + 1;
  localparam int MB_W       = LO_W + 1;
  localparam int P_W        = MA_W + MB_W;
  localparam int STATUS_W   = 3;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(64);

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_ADD   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_CLEARED = 3'd0,
    ST_FIRST   = 3'd1,
    ST_HEAD    = 3'd2,
    ST_TAIL    = 3'd3,
    ST_REJECT  = 3'd4,
    ST_FULL    = 3'd5
  } status_t;

  typedef struct packed {
    logic                      operation;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic [CNT_W-1:0]          pin_count;
    logic signed [COORD_W-1:0] head_x;
    logic signed [COORD_W-1:0] head_y;
    logic signed [COORD_W-1:0] tail_x;
    logic signed [COORD_W-1:0] tail_y;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_TK, S_LIM_LO, S_LIM_HI, S_EX, S_EY,
    S_SQX_LO, S_SQX_HI, S_SQY_LO, S_SQY_HI, S_CMP, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    STP_NONE, STP_LOAD, STP_DECODE, STP_TK, STP_LIM_LO, STP_LIM_HI, STP_EX,
    STP_EY, STP_SQX_LO, STP_SQX_HI, STP_SQY_LO, STP_SQY_HI, STP_CMP
  } step_t;

  typedef struct packed {
    step_t step;
    logic  idle;
    logic  load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic simple;
    logic hit;
    logic side_tail;
  } dp_stat_t;

endpackage

>>> rtl/core/cpcb_ctrl.sv
// Controller state machine of the collinear pin chain builder.
// Depends on cpcb_pkg and the shared assertion macro header.
`include "collinear_pin_chain_builder_unit_defines.svh"

module cpcb_ctrl import cpcb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_free,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        state_nxt = stat.simple ? S_DONE : S_TK;
      end
      S_TK:     state_nxt = S_LIM_LO;
      S_LIM_LO: state_nxt = S_LIM_HI;
      S_LIM_HI: state_nxt = S_EX;
      S_EX:     state_nxt = S_EY;
      S_EY:     state_nxt = S_SQX_LO;
      S_SQX_LO: state_nxt = S_SQX_HI;
      S_SQX_HI: state_nxt = S_SQY_LO;
      S_SQY_LO: state_nxt = S_SQY_HI;
      S_SQY_HI: state_nxt = S_CMP;
      S_CMP: begin
        // A miss at the head end retries the same point at the tail end.
        state_nxt = (stat.hit || stat.side_tail) ? S_DONE : S_EX;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{step: STP_NONE, idle: 1'b0, load_out: 1'b0};
    unique case (state_r)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (in_valid) cmd.step = STP_LOAD;
      end
      S_DECODE: cmd.step = STP_DECODE;
      S_TK:     cmd.step = STP_TK;
      S_LIM_LO: cmd.step = STP_LIM_LO;
      S_LIM_HI: cmd.step = STP_LIM_HI;
      S_EX:     cmd.step = STP_EX;
      S_EY:     cmd.step = STP_EY;
      S_SQX_LO: cmd.step = STP_SQX_LO;
      S_SQX_HI: cmd.step = STP_SQX_HI;
      S_SQY_LO: cmd.step = STP_SQY_LO;
      S_SQY_HI: cmd.step = STP_SQY_HI;
      S_CMP:    cmd.step = STP_CMP;
      S_DONE:   cmd.load_out = out_free;
      default:  cmd.step = STP_NONE;
    endcase
  end

  `CPCB_ASSERT_NEXT(a_tail_retry, (state_r == S_CMP) && !stat.hit && !stat.side_tail,
    state_r == S_EX, "head miss did not retry at the tail end")
  `CPCB_ASSERT_NEXT(a_long_chain, (state_r == S_DECODE) && !stat.simple,
    state_r == S_TK, "chain of two or more points skipped the distance test")

endmodule

>>> rtl/core/cpcb_datapath.sv
// Datapath of the collinear pin chain builder: chain state, one shared
// signed multiplier, accumulator and comparator. Depends on cpcb_pkg.
`include "collinear_pin_chain_builder_unit_defines.svh"

module cpcb_datapath import cpcb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ctrl_cmd_t        cmd,
  input  in_item_t         in_item,
  input  logic [TOL_W-1:0] tolerance,
  output dp_stat_t         stat,
  output out_item_t        result
);

  // Chain state.
  logic signed [COORD_W-1:0] hx_r, hy_r, tx_r, ty_r;
  logic [CNT_W-1:0]          len_r;
  logic                      side_r;

  // Item and work registers.
  logic                      op_r;
  logic signed [COORD_W-1:0] px_r, py_r;
  status_t                   res_r;
  logic [TK_W-1:0]           tk_r;
  logic [LIM_W-1:0]          lim_r;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic signed [EX_W-1:0]    ex_r, ey_r, ex_nxt;
  logic [MAG_W-1:0]          mx_r, my_r, mx_nxt, my_nxt;

  logic [CNT_W-1:0]          k;
  logic                      full;
  logic                      lower;
  logic                      hit;
  logic signed [COORD_W-1:0] ref_x, ref_y;
  logic signed [DIFF_W-1:0]  diff_x, diff_y, d_x, d_y;
  logic signed [EX_W-1:0]    dext_x, dext_y, dsel;
  logic signed [MA_W-1:0]    ma;
  logic signed [MB_W-1:0]    mb;
  logic signed [P_W-1:0]     prod;
  logic [P_W-1:0]            prod_u;
  logic signed [EX_W-1:0]    prod_ex;
  logic [ACC_W-1:0]          add_lo, add_hi, add_sel;
  logic [P_W+LO_W-1:0]       prod_sh;
  logic [EX_W-1:0]           ex_u, ey_u;

  assign k     = len_r - CNT_W'(1);
  assign full  = len_r >= CNT_W'(MAX_POINTS);
  assign lower = (px_r < hx_r) || ((px_r == hx_r) && (py_r < hy_r));

  assign ref_x  = side_r ? tx_r : hx_r;
  assign ref_y  = side_r ? ty_r : hy_r;
  assign diff_x = {px_r[COORD_W-1], px_r} - {ref_x[COORD_W-1], ref_x};
  assign diff_y = {py_r[COORD_W-1], py_r} - {ref_y[COORD_W-1], ref_y};
  assign d_x    = {tx_r[COORD_W-1], tx_r} - {hx_r[COORD_W-1], hx_r};
  assign d_y    = {ty_r[COORD_W-1], ty_r} - {hy_r[COORD_W-1], hy_r};
  assign dext_x = {{(EX_W-DIFF_W){d_x[DIFF_W-1]}}, d_x};
  assign dext_y = {{(EX_W-DIFF_W){d_y[DIFF_W-1]}}, d_y};

  // The head prediction adds the step, the tail prediction subtracts it.
  always_comb begin
    if (cmd.step == STP_EY) begin
      dsel = side_r ? -dext_y : dext_y;
    end else begin
      dsel = side_r ? -dext_x : dext_x;
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.step)
      STP_TK: begin
        ma = {{(MA_W-TOL_W){1'b0}}, tolerance};
        mb = {{(MB_W-K_W){1'b0}}, k};
      end
      STP_LIM_LO: begin
        ma = {{(MA_W-TK_W){1'b0}}, tk_r};
        mb = {1'b0, tk_r[LO_W-1:0]};
      end
      STP_LIM_HI: begin
        ma = {{(MA_W-TK_W){1'b0}}, tk_r};
        mb = {{(MB_W-TKH_W){1'b0}}, tk_r[TK_W-1:LO_W]};
      end
      STP_EX: begin
        ma = {{(MA_W-DIFF_W){diff_x[DIFF_W-1]}}, diff_x};
        mb = {{(MB_W-K_W){1'b0}}, k};
      end
      STP_EY: begin
        ma = {{(MA_W-DIFF_W){diff_y[DIFF_W-1]}}, diff_y};
        mb = {{(MB_W-K_W){1'b0}}, k};
      end
      STP_SQX_LO: begin
        ma = {1'b0, mx_r};
        mb = {1'b0, mx_r[LO_W-1:0]};
      end
      STP_SQX_HI: begin
        ma = {1'b0, mx_r};
        mb = {{(MB_W-HI_W){1'b0}}, mx_r[MAG_W-1:LO_W]};
      end
      STP_SQY_LO: begin
        ma = {1'b0, my_r};
        mb = {1'b0, my_r[LO_W-1:0]};
      end
      STP_SQY_HI: begin
        ma = {1'b0, my_r};
        mb = {{(MB_W-HI_W){1'b0}}, my_r[MAG_W-1:LO_W]};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod    = ma * mb;
  assign prod_u  = prod;
  assign prod_ex = prod[EX_W-1:0];
  assign prod_sh = {prod_u, {LO_W{1'b0}}};
  assign add_lo  = {{(ACC_W-P_W){1'b0}}, prod_u};
  assign add_hi  = prod_sh[ACC_W-1:0];
  assign add_sel = ((cmd.step == STP_LIM_HI) || (cmd.step == STP_SQX_HI) ||
                    (cmd.step == STP_SQY_HI)) ? add_hi : add_lo;
  assign acc_nxt = (cmd.step == STP_LIM_LO || cmd.step == STP_SQX_LO) ?
                   add_lo : acc_r + add_sel;

  assign ex_nxt = prod_ex + dsel;
  assign ex_u   = ex_r;
  assign ey_u   = ey_r;
  assign mx_nxt = ex_r[EX_W-1] ? (~ex_u + EX_W'(1)) : ex_u;
  assign my_nxt = ey_r[EX_W-1] ? (~ey_u + EX_W'(1)) : ey_u;

  assign hit = acc_r < {{(ACC_W-LIM_W){1'b0}}, lim_r};

  // Chain state and search side.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hx_r   <= '0;
      hy_r   <= '0;
      tx_r   <= '0;
      ty_r   <= '0;
      len_r  <= '0;
      side_r <= 1'b0;
    end else begin
      case (cmd.step)
        STP_DECODE: begin
          side_r <= 1'b0;
          if (op_r == OP_CLEAR) begin
            hx_r  <= '0;
            hy_r  <= '0;
            tx_r  <= '0;
            ty_r  <= '0;
            len_r <= '0;
          end else if (!full && (len_r == '0)) begin
            hx_r  <= px_r;
            hy_r  <= py_r;
            tx_r  <= px_r;
            ty_r  <= py_r;
            len_r <= CNT_W'(1);
          end else if (!full && (len_r == CNT_W'(1))) begin
            if (lower) begin
              hx_r <= px_r;
              hy_r <= py_r;
            end else begin
              tx_r <= px_r;
              ty_r <= py_r;
            end
            len_r <= CNT_W'(2);
          end
        end
        STP_CMP: begin
          if (hit) begin
            if (side_r) begin
              tx_r <= px_r;
              ty_r <= py_r;
            end else begin
              hx_r <= px_r;
              hy_r <= py_r;
            end
            len_r <= len_r + CNT_W'(1);
          end else if (!side_r) begin
            side_r <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Item, work registers and result code.
  always_ff @(posedge clk) begin
    case (cmd.step)
      STP_LOAD: begin
        op_r <= in_item.operation;
        px_r <= in_item.point_x;
        py_r <= in_item.point_y;
      end
      STP_DECODE: begin
        if (op_r == OP_CLEAR) begin
          res_r <= ST_CLEARED;
        end else if (full) begin
          res_r <= ST_FULL;
        end else if (len_r == '0) begin
          res_r <= ST_FIRST;
        end else if (len_r == CNT_W'(1)) begin
          res_r <= lower ? ST_HEAD : ST_TAIL;
        end
      end
      STP_TK:     tk_r  <= prod_u[TK_W-1:0];
      STP_LIM_LO: acc_r <= acc_nxt;
      STP_LIM_HI: lim_r <= acc_nxt[LIM_W-1:0];
      STP_EX:     ex_r  <= ex_nxt;
      STP_EY: begin
        ey_r <= ex_nxt;
        mx_r <= mx_nxt;
      end
      STP_SQX_LO: begin
        acc_r <= acc_nxt;
        my_r  <= my_nxt;
      end
      STP_SQX_HI: acc_r <= acc_nxt;
      STP_SQY_LO: acc_r <= acc_nxt;
      STP_SQY_HI: acc_r <= acc_nxt;
      STP_CMP: begin
        if (hit) begin
          res_r <= side_r ? ST_TAIL : ST_HEAD;
        end else if (side_r) begin
          res_r <= ST_REJECT;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.simple    = (op_r == OP_CLEAR) || full || (len_r < CNT_W'(2));
  assign stat.hit       = hit;
  assign stat.side_tail = side_r;

  assign result.status    = res_r;
  assign result.pin_count = len_r;
  assign result.head_x    = hx_r;
  assign result.head_y    = hy_r;
  assign result.tail_x    = tx_r;
  assign result.tail_y    = ty_r;

  `CPCB_ASSERT_IMPL(a_len_bound, 1'b1, len_r <= CNT_W'(MAX_POINTS),
    "chain length exceeds the maximum point count")
  `CPCB_ASSERT_NEXT(a_hit_grows, (cmd.step == STP_CMP) && hit,
    len_r == $past(len_r) + CNT_W'(1), "accepted point did not grow the chain")

endmodule

>>> rtl/core/collinear_pin_chain_builder_unit.sv
// Top level of the collinear pin chain builder: handshake, tolerance register
// and result register around cpcb_ctrl and cpcb_datapath (uses cpcb_pkg).
//
// Usage: an item is transferred on the input channel when in_valid is high
// and in_stall is low. Operation clear empties the chain; operation add
// offers a point. Every item yields exactly one result on the output channel,
// transferred when out_valid is high and out_stall is low, in item order.
// The tolerance register is written through cfg_wr_en/cfg_wr_data while idle.
// Sequence: a clear, a point into a full chain, and the first or second point
// of a chain go from decode straight to the done state. From the third point
// on, the item also passes the limit steps and the distance test at the head
// end, and after a head miss the test at the tail end, which hits or rejects.
// One item is worked on at a time and the controller returns to idle before
// the next input transfer is taken. The work is paced by the single shared 39x20
// multiplier: the squared limit takes three passes and each end of the chain
// six more plus a compare.
// The result sits in an output register, so the next input transfer is taken
// while an earlier result still waits; when out_stall holds the register
// full, the following result waits in the controller before it is loaded.
// Reset (rst_n low, synchronous) empties the chain, sets tolerance to 64 and
// drops out_valid.
`include "collinear_pin_chain_builder_unit_defines.svh"

module collinear_pin_chain_builder_unit import cpcb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_wr_en,
  input  logic [TOL_W-1:0] cfg_wr_data
);

  logic [TOL_W-1:0] tol_r;
  logic             out_valid_r;
  out_item_t        out_item_r;
  logic             out_free;
  ctrl_cmd_t        ctrl_cmd;
  dp_stat_t         dp_stat;
  out_item_t        dp_result;

  // The result register can be loaded when it is empty or is being taken.
  assign out_free = !out_valid_r || !out_stall;

  // Tolerance register; the user must write it only while no item is in flight (not enforced here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  cpcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (dp_stat),
    .cmd      (ctrl_cmd)
  );

  cpcb_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ctrl_cmd),
    .in_item   (in_item),
    .tolerance (tol_r),
    .stat      (dp_stat),
    .result    (dp_result)
  );

  // Output register: valid is held until the downstream transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl_cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.load_out) begin
      out_item_r <= dp_result;
    end
  end

  assign in_stall  = !ctrl_cmd.idle;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `CPCB_ASSERT_NEXT(a_load_shows, ctrl_cmd.load_out, out_valid_r,
    "loaded result is not presented")
  `CPCB_ASSERT_IMPL(a_no_overwrite, ctrl_cmd.load_out, out_free,
    "result register overwritten before its transfer")

endmodule
